// ===== sv/mdp_pkg.sv =====
// shared types, constants and saturating helpers for the marquee damped motion block
// no dependencies
`default_nettype none
package mdp_pkg;

  localparam int WW = 64;

  typedef logic signed [WW-1:0] wide_t;

  localparam wide_t WIDE = 64'sh2000_0000_0000_0000;

  typedef enum logic [1:0] {
    CFG_SMOOTH = 2'd0,
    CFG_PROJ   = 2'd1,
    CFG_SPEED  = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdp_op_e;

  typedef struct packed {
    logic    start;
    mdp_op_e op;
  } mdp_ctl_t;

  function automatic wide_t clampw(input wide_t v);
    wide_t r;
    r = v;
    if (v > WIDE) r = WIDE;
    else if (v < -WIDE) r = -WIDE;
    return r;
  endfunction

  function automatic wide_t addw(input wide_t a, input wide_t b);
    return clampw(a + b);
  endfunction

  function automatic wide_t subw(input wide_t a, input wide_t b);
    return clampw(a - b);
  endfunction

  function automatic wide_t absw(input wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/marquee_damped_motion_top.sv =====
// marquee damped motion top level: sequencer, state and stream ports
// depends on mdp_pkg and mdp_alu
//
// When elapsed is zero a tick skips the spring steps; otherwise it runs
// 10 multiplies and 2 divides, with one more multiply on the tick where a
// coast starts. The tick time is set by the single bit-serial multiply/divide
// unit, which every step of the spring goes through one after another.
// A finished result sits in the output register while the next tick is taken.
`default_nettype none
module marquee_damped_motion_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // active, elapsed[21:0], zero pad
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // position[31:0], speed[31:0], coasting_now, zero pad
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [30:0] cfg_data_i
);
  import mdp_pkg::*;

  localparam longint ONE_L    = longint'(1) << FRAC_BITS;
  localparam longint MIN_L    = (ONE_L + 50) / 100;
  localparam longint C048_L   = (48 * ONE_L + 50) / 100;
  localparam longint C0235_L  = (235 * ONE_L + 500) / 1000;
  localparam longint SDIST_L  = (5 * ONE_L + 5000) / 10000;
  localparam longint SVEL_L   = (2 * ONE_L + 500) / 1000;
  localparam logic [21:0] MIN_ST = 22'(MIN_L);
  localparam wide_t ONE     = wide_t'(ONE_L);
  localparam wide_t C048    = wide_t'(C048_L);
  localparam wide_t C0235   = wide_t'(C0235_L);
  localparam wide_t SDIST   = wide_t'(SDIST_L);
  localparam wide_t SVEL    = wide_t'(SVEL_L);
  localparam wide_t NUM_OM  = wide_t'(ONE_L) <<< (FRAC_BITS + 1);
  localparam wide_t NUM_DEC = wide_t'(ONE_L) <<< FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CGOAL, ST_PICK, ST_SPR, ST_OMEGA, ST_X, ST_D1, ST_D2, ST_D3,
    ST_DECAY, ST_MAXD, ST_T1, ST_TMP, ST_T2, ST_NV, ST_NP, ST_CHK, ST_FIN
  } state_e;

  state_e state_q;
  logic [21:0] smooth_q, proj_q, st_q, el_q;
  logic [30:0] speed_q, offset_q;
  logic signed [31:0] pos_q, vel_q, cgoal_q;
  logic prev_q, coast_q, launched_q;
  wide_t goal_q, omega_q, x_q, den_q, decay_q, disp_q, base_q, tmp_q, acc_q, nv_q, np_q;
  logic out_valid_q, out_coast_q;
  logic signed [31:0] out_pos_q, out_spd_q;

  mdp_ctl_t alu_ctl;
  wide_t    op_a, op_b, alu_res;
  logic     alu_done, compute;

  wide_t pos_w, vel_w, top_w, g_c, d0_c, disp_c, base_c, np_c, nv_c;
  logic  ovr_c, settle_c, coast_end_c, s_acc, out_load;
  logic [21:0] half_st;

  assign pos_w   = wide_t'(pos_q);
  assign vel_w   = wide_t'(vel_q);
  assign top_w   = wide_t'({33'd0, offset_q});
  assign half_st = {1'b0, smooth_q[21:1]};
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    compute = 1'b1;
    op_a = '0;
    op_b = '0;
    alu_ctl.op = OP_MUL;
    unique case (state_q)
      ST_CGOAL: begin op_a = vel_w;   op_b = wide_t'({42'd0, proj_q}); end
      ST_OMEGA: begin op_a = NUM_OM;  op_b = wide_t'({42'd0, st_q}); alu_ctl.op = OP_DIV; end
      ST_X:     begin op_a = omega_q; op_b = wide_t'({42'd0, el_q}); end
      ST_D1:    begin op_a = C0235;   op_b = x_q; end
      ST_D2, ST_D3: begin op_a = x_q; op_b = den_q; end
      ST_DECAY: begin op_a = NUM_DEC; op_b = den_q; alu_ctl.op = OP_DIV; end
      ST_MAXD:  begin op_a = wide_t'({33'd0, speed_q}); op_b = wide_t'({42'd0, st_q}); end
      ST_T1:    begin op_a = omega_q; op_b = disp_q; end
      ST_TMP:   begin op_a = acc_q;   op_b = wide_t'({42'd0, el_q}); end
      ST_T2:    begin op_a = omega_q; op_b = tmp_q; end
      ST_NV:    begin op_a = acc_q;   op_b = decay_q; end
      ST_NP:    begin op_a = addw(disp_q, tmp_q); op_b = decay_q; end
      default:  compute = 1'b0;
    endcase
    alu_ctl.start = compute && !launched_q;
  end

  mdp_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    g_c = addw(pos_w, alu_res);
    if (g_c < pos_w) g_c = pos_w;
    if (g_c > top_w) g_c = top_w;
    d0_c = subw(pos_w, goal_q);
    disp_c = d0_c;
    if (d0_c > alu_res) disp_c = alu_res;
    else if (d0_c < -alu_res) disp_c = -alu_res;
    base_c = subw(pos_w, disp_c);
    ovr_c = ((goal_q - pos_w) > 0) == (np_q > goal_q);
    settle_c = (absw(subw(np_q, goal_q)) <= SDIST) && (absw(nv_q) <= SVEL);
    if (ovr_c || settle_c) begin
      np_c = goal_q;
      nv_c = '0;
    end else begin
      np_c = np_q;
      nv_c = nv_q;
    end
    coast_end_c = coast_q && (pos_q == cgoal_q) && (vel_q == '0);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_coast_q, out_spd_q, out_pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      smooth_q <= 22'd16384;
      proj_q <= 22'd16384;
      speed_q <= 31'h7FFF_FFFF;
      offset_q <= '0;
      st_q <= '0;
      el_q <= '0;
      pos_q <= '0;
      vel_q <= '0;
      cgoal_q <= '0;
      prev_q <= 1'b0;
      coast_q <= 1'b0;
      launched_q <= 1'b0;
      goal_q <= '0;
      omega_q <= '0;
      x_q <= '0;
      den_q <= '0;
      decay_q <= '0;
      disp_q <= '0;
      base_q <= '0;
      tmp_q <= '0;
      acc_q <= '0;
      nv_q <= '0;
      np_q <= '0;
      out_valid_q <= 1'b0;
      out_coast_q <= 1'b0;
      out_pos_q <= '0;
      out_spd_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SMOOTH: smooth_q <= cfg_data_i[21:0];
          CFG_PROJ:   proj_q <= cfg_data_i[21:0];
          CFG_SPEED:  speed_q <= cfg_data_i;
          CFG_OFFSET: offset_q <= cfg_data_i;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (alu_done) launched_q <= 1'b0;
      else if (alu_ctl.start) launched_q <= 1'b1;

      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            el_q <= s_axis_tdata[22:1];
            if (s_axis_tdata[0]) begin
              prev_q <= 1'b1;
              coast_q <= 1'b0;
              goal_q <= top_w;
              st_q <= (smooth_q < MIN_ST) ? MIN_ST : smooth_q;
              state_q <= ST_SPR;
            end else begin
              prev_q <= 1'b0;
              if (prev_q && vel_w > SVEL && pos_w < top_w) state_q <= ST_CGOAL;
              else state_q <= ST_PICK;
            end
          end
        end
        ST_CGOAL: if (alu_done) begin
          coast_q <= 1'b1;
          cgoal_q <= g_c[31:0];
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          if (coast_q) begin
            goal_q <= wide_t'(cgoal_q);
            st_q <= (half_st < MIN_ST) ? MIN_ST : half_st;
          end else begin
            goal_q <= '0;
            st_q <= (smooth_q < MIN_ST) ? MIN_ST : smooth_q;
          end
          state_q <= ST_SPR;
        end
        ST_SPR: state_q <= (el_q == '0) ? ST_FIN : ST_OMEGA;
        ST_OMEGA: if (alu_done) begin omega_q <= alu_res; state_q <= ST_X; end
        ST_X:     if (alu_done) begin x_q <= alu_res; state_q <= ST_D1; end
        ST_D1:    if (alu_done) begin den_q <= addw(C048, alu_res); state_q <= ST_D2; end
        ST_D2:    if (alu_done) begin den_q <= addw(ONE, alu_res); state_q <= ST_D3; end
        ST_D3:    if (alu_done) begin den_q <= addw(ONE, alu_res); state_q <= ST_DECAY; end
        ST_DECAY: if (alu_done) begin decay_q <= alu_res; state_q <= ST_MAXD; end
        ST_MAXD:  if (alu_done) begin
          disp_q <= disp_c;
          base_q <= base_c;
          state_q <= ST_T1;
        end
        ST_T1:    if (alu_done) begin acc_q <= addw(vel_w, alu_res); state_q <= ST_TMP; end
        ST_TMP:   if (alu_done) begin tmp_q <= alu_res; state_q <= ST_T2; end
        ST_T2:    if (alu_done) begin acc_q <= subw(vel_w, alu_res); state_q <= ST_NV; end
        ST_NV:    if (alu_done) begin nv_q <= alu_res; state_q <= ST_NP; end
        ST_NP:    if (alu_done) begin np_q <= addw(base_q, alu_res); state_q <= ST_CHK; end
        ST_CHK: begin
          pos_q <= sat32(np_c);
          vel_q <= sat32(nv_c);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            if (coast_end_c) coast_q <= 1'b0;
            out_pos_q <= pos_q;
            out_spd_q <= vel_q;
            out_coast_q <= coast_q && !coast_end_c;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/mdp_alu.sv =====
// bit-serial shared unit: saturating fixed-point multiply and restoring divide
// depends on mdp_pkg
`default_nettype none
module mdp_alu #(
  parameter int FRAC_BITS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire  mdp_pkg::mdp_ctl_t ctl_i,
  input  wire  mdp_pkg::wide_t   a_i,
  input  wire  mdp_pkg::wide_t   b_i,
  output logic                   done_o,
  output mdp_pkg::wide_t         res_o
);
  import mdp_pkg::*;

  localparam int AW = FRAC_BITS + 64;
  localparam int NB = 2 * FRAC_BITS + 2;

  logic          busy_q, done_q, neg_q, sat_q;
  mdp_op_e       op_q;
  logic [5:0]    cnt_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [61:0]   ua_q, ub_q, dvs_q;
  logic [63:0]   rem_q, quo_q, rem_sh;
  logic          acc_ovf, rem_ge;
  wide_t         ua_w, ub_w, mag;

  assign ua_w    = a_i[WW-1] ? -a_i : a_i;
  assign ub_w    = b_i[WW-1] ? -b_i : b_i;
  assign acc_d   = {acc_q[AW-2:0], 1'b0} + (ub_q[61] ? AW'(ua_q) : '0);
  // a full product wider than 64 bits saturates
  assign acc_ovf = |acc_d[AW-1:64];
  assign rem_sh  = {rem_q[62:0], quo_q[63]};
  assign rem_ge  = rem_sh >= {2'b00, dvs_q};
  assign mag     = sat_q ? WIDE : wide_t'({2'b00, acc_q[FRAC_BITS+61:FRAC_BITS]});
  assign res_o   = (op_q == OP_DIV) ? wide_t'(quo_q) : (neg_q ? -mag : mag);
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      sat_q  <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
      acc_q  <= '0;
      ua_q   <= '0;
      ub_q   <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctl_i.op;
        if (ctl_i.op == OP_MUL) begin
          neg_q <= a_i[WW-1] ^ b_i[WW-1];
          sat_q <= 1'b0;
          acc_q <= '0;
          ua_q  <= ua_w[61:0];
          ub_q  <= ub_w[61:0];
          cnt_q <= 6'd61;
        end else begin
          rem_q <= '0;
          quo_q <= a_i << (WW - NB);
          dvs_q <= b_i[61:0];
          cnt_q <= 6'(NB - 1);
        end
      end else if (busy_q) begin
        if (op_q == OP_MUL) begin
          ub_q <= {ub_q[60:0], 1'b0};
          if (!sat_q) begin
            acc_q <= acc_d;
            sat_q <= acc_ovf;
          end
        end else begin
          rem_q <= rem_ge ? rem_sh - {2'b00, dvs_q} : rem_sh;
          quo_q <= {quo_q[62:0], rem_ge};
        end
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mdp_checker.sv =====
// port-level checks for the marquee damped motion block, bound to the top level
// no dependencies
`default_nettype none
module mdp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [23:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [71:0] m_axis_tdata
);

  // one tick in flight at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a tick is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transfer changed");

  // a tick cannot finish in the cycle after it was taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind marquee_damped_motion_top mdp_checker u_mdp_checker (.*);
`default_nettype wire
